### src/pixel_run_length_packer_macros.svh
// ----------------------------------------------------------------------------
// Pixel run-length packer assertion macros
// Shared property shorthands for the checker, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_RUN_LENGTH_PACKER_MACROS_SVH
`define PIXEL_RUN_LENGTH_PACKER_MACROS_SVH

// Same-cycle implication.
`define PRLP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PRLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/prlp_pkg.sv
// ----------------------------------------------------------------------------
// prlp_pkg
// Types and constants of the pixel run-length packer.
// ----------------------------------------------------------------------------
`default_nettype none

package prlp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLACE,
    ST_REP_OUT,
    ST_LIT_FILL,
    ST_LIT_OUT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_LITERAL,
    MODE_REPEAT
  } mode_t;

  localparam logic [1:0] FMT_8     = 2'd0;
  localparam logic [1:0] FMT_16    = 2'd1;
  localparam logic [1:0] FMT_32    = 2'd2;

  localparam int PIECE_SLOTS = 4;
  localparam int SLOT_W      = 32;
  localparam int HDR_LSB     = 0;
  localparam int CNT_LSB     = 8;
  localparam int PXA_LSB     = 11;
  localparam int PAD_LSB     = PXA_LSB + PIECE_SLOTS * SLOT_W;
  localparam int OUT_DATA_W  = 144;

endpackage

`default_nettype wire

### src/pixel_run_length_packer.sv
// ----------------------------------------------------------------------------
// pixel_run_length_packer
// PackBits-style run-length encoder for 8, 16 or 32 bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one pixel per transaction, tdata = pixel, tlast = final pixel
//   of the image (flushes every open packet).
//   m_* stream: one packet piece per transaction, up to four pixel slots.
//   tuser = first piece of a packet, tlast = final piece of the image.
//   cfg_* channel: pixel_format, always ready; write only while idle.
// Timing:
//   A pixel is taken in ST_IDLE; s_tready is low while the sequencer works.
//   A pixel that only opens or extends a packet passes through ST_PLACE and
//   ST_DONE (the first pixel of an image skips ST_PLACE). Each repeat piece
//   adds a pass through ST_REP_OUT, and a packet closed by a pixel that then
//   opens the other kind returns to ST_PLACE to place that pixel again. Literal
//   pixels sit in a store with one write port and drain through its one
//   registered read port: each literal piece is read in ST_LIT_FILL and sent
//   from ST_LIT_OUT. The next pixel is taken only once the sequencer is idle.
// Reset:
//   Synchronous, active high: no packet open, format 32 bit. The literal
//   store needs no clearing; entries are read only after being written.
// Stall:
//   A finished piece waits in the output register; the sequencer holds in
//   its emit state until the register frees, and no result is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_run_length_packer import prlp_pkg::*; #(
  parameter int MAX_RUN    = 127,
  parameter int PIXEL_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_data,    // pixel_format
  // pixel input
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [31:0]           s_tdata,     // pixel_value
  input  wire logic                  s_tlast,     // last_pixel
  // packet pieces
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // header_byte[7:0], pixel_count[10:8], pixel_a[42:11], pixel_b[74:43],
  // pixel_c[106:75], pixel_d[138:107], zero pad[143:139]
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic                       m_tuser,     // packet_start
  output logic                       m_tlast      // image_end
);

  localparam int PW   = PIXEL_BITS;
  localparam int AW   = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int CW   = $clog2(MAX_RUN + 1);
  localparam int SH8  = PW - 8;
  localparam int SH16 = (PW > 16) ? PW - 16 : 0;
  localparam logic [PW-1:0] ONES   = {PW{1'b1}};
  localparam logic [PW-1:0] MASK8  = ONES >> SH8;
  localparam logic [PW-1:0] MASK16 = ONES >> SH16;

  state_t          state, state_next;
  mode_t           mode;
  logic [1:0]      fmt;
  logic [CW-1:0]   lit_fill, rep_fill;
  logic [PW-1:0]   held_px;
  logic            held_valid;
  logic [PW-1:0]   cur_px;
  logic            cur_last;
  logic [PW-1:0]   place_px;   // pixel being placed
  logic            place_eq;   // it equals its successor
  logic            phase;      // 0: held pixel, 1: final pixel of image
  logic            ret_place;  // after an emit, re-enter placement

  // literal drain
  logic [CW-1:0]   base;
  logic [2:0]      iss_cnt, cap_cnt;
  logic            rd_vld;
  logic [PW-1:0]   rd_data;
  logic [PW-1:0]   slot [PIECE_SLOTS];
  logic [PW-1:0]   lit_mem [MAX_RUN];

  // output register
  logic            out_start, out_end;
  logic [7:0]      out_hdr;
  logic [2:0]      out_cnt;
  logic [SLOT_W-1:0] out_px [PIECE_SLOTS];

  logic [PW-1:0]   in_mask, in_px;
  logic            in_accept, out_free;
  logic [CW-1:0]   rep_inc, lit_inc, remaining;
  logic [2:0]      piece_cnt;
  logic            drain_last;

  // control from the sequencer
  typedef struct packed {
    logic mem_we;
    logic issue;
    logic rep_fire;
    logic lit_fire;
  } ctrl_t;
  ctrl_t ctrl;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid & s_tready;
  assign out_free  = ~m_tvalid | m_tready;

  always_comb begin
    case (fmt)
      FMT_8:   in_mask = MASK8;
      FMT_16:  in_mask = MASK16;
      default: in_mask = ONES;   // 32 bit and the unused code
    endcase
  end
  assign in_px = s_tdata[PW-1:0] & in_mask;

  assign rep_inc    = rep_fill + CW'(1);
  assign lit_inc    = lit_fill + CW'(1);
  assign remaining  = lit_fill - base;
  assign piece_cnt  = (int'(remaining) >= PIECE_SLOTS) ? 3'(PIECE_SLOTS) : 3'(remaining);
  assign drain_last = (CW'(base + CW'(piece_cnt)) == lit_fill);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) state_next = held_valid ? ST_PLACE : ST_DONE;
      end
      ST_PLACE: begin
        unique case (mode)
          MODE_REPEAT: begin
            if (!place_eq || int'(rep_inc) == MAX_RUN) state_next = ST_REP_OUT;
            else                                       state_next = ST_DONE;
          end
          MODE_LITERAL: begin
            if (place_eq || int'(lit_inc) == MAX_RUN) state_next = ST_LIT_FILL;
            else                                      state_next = ST_DONE;
          end
          default: state_next = ST_DONE;  // opens a packet, never full at once
        endcase
      end
      ST_REP_OUT: begin
        if (out_free) state_next = ret_place ? ST_PLACE : ST_DONE;
      end
      ST_LIT_FILL: begin
        if (cap_cnt == piece_cnt) state_next = ST_LIT_OUT;
      end
      ST_LIT_OUT: begin
        if (out_free) begin
          if (drain_last) state_next = ret_place ? ST_PLACE : ST_DONE;
          else            state_next = ST_LIT_FILL;
        end
      end
      ST_DONE: begin
        if (!phase)                                       state_next = cur_last ? ST_PLACE : ST_IDLE;
        else if (mode == MODE_LITERAL && lit_fill != '0) state_next = ST_LIT_FILL;
        else                                              state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl          = '0;
    ctrl.mem_we   = (state == ST_PLACE) && !place_eq && (mode != MODE_REPEAT);
    ctrl.issue    = (state == ST_LIT_FILL) && (iss_cnt < piece_cnt);
    ctrl.rep_fire = (state == ST_REP_OUT) && out_free;
    ctrl.lit_fire = (state == ST_LIT_OUT) && out_free;
  end

  // literal store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.mem_we) lit_mem[lit_fill[AW-1:0]] <= place_px;
    rd_data <= lit_mem[AW'(base + CW'(iss_cnt))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fmt        <= FMT_32;
      mode       <= MODE_IDLE;
      lit_fill   <= '0;
      rep_fill   <= '0;
      held_valid <= 1'b0;
      phase      <= 1'b0;
      rd_vld     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= ctrl.issue;
      if (cfg_valid) fmt <= cfg_data;
      // a new piece loads only when the register is free
      if (ctrl.rep_fire || ctrl.lit_fire) m_tvalid <= 1'b1;
      else if (m_tready)                  m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            cur_px   <= in_px;
            cur_last <= s_tlast;
            place_px <= held_px;
            // the one shared compare: held pixel against its successor
            place_eq <= held_valid && (held_px == in_px);
            phase    <= 1'b0;
          end
        end
        ST_PLACE: begin
          unique case (mode)
            MODE_REPEAT: begin
              ret_place <= !place_eq;
              if (place_eq) rep_fill <= rep_inc;   // full run emits MAX_RUN
            end
            MODE_LITERAL: begin
              if (place_eq) begin
                ret_place <= 1'b1;
              end else begin
                lit_fill  <= lit_inc;
                ret_place <= 1'b0;
              end
            end
            default: begin
              if (place_eq) begin
                mode     <= MODE_REPEAT;
                rep_fill <= CW'(1);
              end else begin
                mode     <= MODE_LITERAL;
                lit_fill <= lit_inc;
              end
            end
          endcase
          base    <= '0;
          iss_cnt <= '0;
          cap_cnt <= '0;
          for (int j = 0; j < PIECE_SLOTS; j++) slot[j] <= '0;
        end
        ST_REP_OUT: begin
          if (ctrl.rep_fire) begin
            out_start <= 1'b1;
            out_hdr   <= 8'(rep_fill);
            out_cnt   <= 3'd1;
            out_end   <= 1'b0;
            out_px[0] <= SLOT_W'(place_px);
            for (int j = 1; j < PIECE_SLOTS; j++) out_px[j] <= '0;
            rep_fill  <= '0;
            mode      <= MODE_IDLE;
          end
        end
        ST_LIT_FILL: begin
          if (ctrl.issue) iss_cnt <= iss_cnt + 3'd1;
          if (rd_vld) begin
            slot[cap_cnt[1:0]] <= rd_data;
            cap_cnt            <= cap_cnt + 3'd1;
          end
        end
        ST_LIT_OUT: begin
          if (ctrl.lit_fire) begin
            out_start <= (base == '0);
            out_hdr   <= (base == '0) ? 8'(9'd256 - 9'(lit_fill)) : 8'd0;
            out_cnt   <= piece_cnt;
            out_end   <= phase && drain_last;  // a drain in phase 1 holds the image's final pixel
            for (int j = 0; j < PIECE_SLOTS; j++) begin
              out_px[j] <= SLOT_W'(slot[j]);
              slot[j]   <= '0;
            end
            base    <= CW'(base + CW'(piece_cnt));
            iss_cnt <= '0;
            cap_cnt <= '0;
            if (drain_last) begin
              lit_fill <= '0;
              mode     <= MODE_IDLE;
            end
          end
        end
        ST_DONE: begin
          if (!phase) begin
            if (cur_last) begin
              phase    <= 1'b1;
              place_px <= cur_px;
              place_eq <= 1'b0;   // pixel past the end counts as different
            end else begin
              held_px    <= cur_px;
              held_valid <= 1'b1;
            end
          end else if (mode == MODE_LITERAL && lit_fill != '0) begin
            ret_place <= 1'b0;
            base      <= '0;
            iss_cnt   <= '0;
            cap_cnt   <= '0;
            for (int j = 0; j < PIECE_SLOTS; j++) slot[j] <= '0;
          end else begin
            mode       <= MODE_IDLE;
            lit_fill   <= '0;
            rep_fill   <= '0;
            held_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {(OUT_DATA_W - PAD_LSB)'(0), out_px[3], out_px[2], out_px[1], out_px[0],
                    out_cnt, out_hdr};
  assign m_tuser = out_start;
  assign m_tlast = out_end;

endmodule

`default_nettype wire

### src/prlp_checker.sv
// ----------------------------------------------------------------------------
// prlp_checker
// Port-level checks on the packet piece stream of the packer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_run_length_packer_macros.svh"

module prlp_checker import prlp_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic                  m_tuser
);

  logic [2:0] cnt;
  logic [7:0] hdr;

  assign cnt = m_tdata[CNT_LSB +: 3];
  assign hdr = m_tdata[HDR_LSB +: 8];

  `PRLP_ASSERT_NEXT(a_valid_hold, m_tvalid && !m_tready, m_tvalid, "piece dropped under stall")
  `PRLP_ASSERT_NEXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "piece changed under stall")
  `PRLP_ASSERT_IMPL(a_count_range, m_tvalid, cnt != 3'd0 && cnt <= 3'd4, "slot count out of range")
  `PRLP_ASSERT_IMPL(a_cont_header, m_tvalid && !m_tuser, hdr == 8'd0, "header on continuation piece")
  `PRLP_ASSERT_IMPL(a_repeat_one, m_tvalid && m_tuser && !hdr[7], cnt == 3'd1, "repeat piece with more than one pixel")

endmodule

bind pixel_run_length_packer prlp_checker u_prlp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// Pixel run-length packer testbench
// Streams pixel images into the packer and predicts every packet piece with a
// behavioral encoder. Each piece is compared field by field as it leaves the
// block. Phases switch the pixel format and the idle patterns on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import prlp_pkg::*;

  localparam int RUN_CAP     = 127;     // longest repeat or literal packet
  localparam int TAIL_CYCLES = 20;      // covers a literal piece plus slack
  localparam int CYCLE_LIMIT = 400000;
  // Code 3 is not a listed format; the block treats it as 32-bit pixels.
  localparam logic [1:0] FMT_WIDE = 2'd3;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        drain;   // hold this pixel back until no piece is owed
  } pixel_item_t;

  typedef struct packed {
    logic        start;
    logic [7:0]  header;
    logic [2:0]  count;
    logic [31:0] pa, pb, pc, pd;
    logic        image_end;
  } piece_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_data = FMT_32;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  // Encoder state, mirrored from the block's observable behavior.
  logic [1:0]  fmt_now = FMT_32;
  logic [31:0] lit_buf [RUN_CAP + 4];   // padded so a last short piece reads safely
  int          lit_len = 0;
  int          rep_len = 0;
  logic [31:0] held_px = '0;
  logic        held_ok = 1'b0;
  mode_t       pk_mode = MODE_IDLE;

  piece_t      step_pieces[$];          // pieces caused by the current pixel
  piece_t      pending_pieces[$];       // pieces owed by the block, oldest first
  pixel_item_t pixel_q[$];              // pixels not yet handed to the driver

  int          n_pushed = 0;
  int          n_taken = 0;
  int          n_cfg = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          gap_pct = 0;             // sender idle chance, percent
  int          stall_pct = 0;           // receiver stall chance, percent
  logic [1:0]  gen_fmt = FMT_32;        // format the generator shapes pixels for
  logic [31:0] gen_prev = '0;
  logic        px_hs = 1'b0;            // pixel transaction at the last rising edge

  pixel_run_length_packer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),     // pixel_value
    .s_tlast   (s_tlast),     // last_pixel
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),     // header, count, pixel_a..pixel_d, pad
    .m_tuser   (m_tuser),     // packet_start
    .m_tlast   (m_tlast)      // image_end
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Encoder
  // --------------------------------------------------------------------------
  function automatic logic [31:0] width_bits(input logic [1:0] f);
    case (f)
      FMT_8:   return 32'h0000_00FF;
      FMT_16:  return 32'h0000_FFFF;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Slots past the valid count read as zero.
  task automatic add_piece(input logic start, input logic [7:0] header, input int count,
                           input logic [31:0] s0, s1, s2, s3);
    piece_t p;
    p.start     = start;
    p.header    = header;
    p.count     = 3'(count);
    p.pa        = s0;
    p.pb        = (count > 1) ? s1 : '0;
    p.pc        = (count > 2) ? s2 : '0;
    p.pd        = (count > 3) ? s3 : '0;
    p.image_end = 1'b0;
    step_pieces.push_back(p);
  endtask

  // Literal packet: header 256-n, pixels four to a piece.
  task automatic flush_literal();
    int k;
    int c;
    for (k = 0; k < lit_len; k += 4) begin
      c = (lit_len - k < 4) ? lit_len - k : 4;
      add_piece(k == 0, (k == 0) ? 8'(256 - lit_len) : 8'h00, c,
                lit_buf[k], lit_buf[k + 1], lit_buf[k + 2], lit_buf[k + 3]);
    end
    lit_len = 0;
    pk_mode = MODE_IDLE;
  endtask

  task automatic flush_repeat(input logic [31:0] px);
    add_piece(1'b1, 8'(rep_len), 1, px, '0, '0, '0);
    rep_len = 0;
    pk_mode = MODE_IDLE;
  endtask

  // One position: px and whether it matches its successor.
  task automatic place_position(input logic [31:0] px, input logic same);
    if (pk_mode == MODE_REPEAT && !same) flush_repeat(px);
    if (pk_mode == MODE_LITERAL && same) flush_literal();
    if (pk_mode == MODE_IDLE) begin
      pk_mode = same ? MODE_REPEAT : MODE_LITERAL;
      lit_len = 0;
      rep_len = 0;
    end
    if (pk_mode == MODE_REPEAT) begin
      rep_len++;
      if (rep_len >= RUN_CAP) flush_repeat(px);
    end else begin
      lit_buf[lit_len] = px;
      lit_len++;
      if (lit_len >= RUN_CAP) flush_literal();
    end
  endtask

  // A pixel is only placed once its successor is known; the final pixel is
  // placed against an imaginary differing successor.
  task automatic encode_pixel(input logic [31:0] data, input logic last);
    logic [31:0] v;
    piece_t      p;
    int          i;
    v = data & width_bits(fmt_now);
    step_pieces = {};
    if (held_ok) place_position(held_px, held_px == v);
    if (last) begin
      place_position(v, 1'b0);
      if (pk_mode == MODE_LITERAL && lit_len > 0) flush_literal();
      pk_mode = MODE_IDLE;
      lit_len = 0;
      rep_len = 0;
      held_px = '0;
      held_ok = 1'b0;
    end else begin
      held_px = v;
      held_ok = 1'b1;
    end
    for (i = 0; i < step_pieces.size(); i++) begin
      p = step_pieces[i];
      p.image_end = last && (i == step_pieces.size() - 1);
      pending_pieces.push_back(p);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: config and pixel transactions feed the encoder first, then a
  // piece transaction is checked against the oldest owed piece.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    piece_t want;
    if (rst) begin
      px_hs <= 1'b0;
    end else begin
      px_hs <= s_tvalid && s_tready;
      if (cfg_valid && cfg_ready) begin
        fmt_now = cfg_data;
        n_cfg++;
      end
      if (s_tvalid && s_tready) begin
        encode_pixel(s_tdata, s_tlast);
        n_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (pending_pieces.size() == 0) begin
          $error("unexpected piece: header 0x%0h, count %0d",
                 m_tdata[HDR_LSB +: 8], m_tdata[CNT_LSB +: 3]);
          mismatches++;
        end else begin
          want = pending_pieces.pop_front();
          check_field("packet_start", 32'(want.start), 32'(m_tuser));
          check_field("header_byte", 32'(want.header), 32'(m_tdata[HDR_LSB +: 8]));
          check_field("pixel_count", 32'(want.count), 32'(m_tdata[CNT_LSB +: 3]));
          check_field("pixel_a", want.pa, m_tdata[PXA_LSB +: SLOT_W]);
          check_field("pixel_b", want.pb, m_tdata[PXA_LSB + SLOT_W +: SLOT_W]);
          check_field("pixel_c", want.pc, m_tdata[PXA_LSB + 2 * SLOT_W +: SLOT_W]);
          check_field("pixel_d", want.pd, m_tdata[PXA_LSB + 3 * SLOT_W +: SLOT_W]);
          check_field("image_end", 32'(want.image_end), 32'(m_tlast));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: holds a pixel until its transaction, then maybe idles. A pixel
  // marked drain waits until every owed piece has left.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    pixel_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !px_hs) begin
      // not taken yet, keep it on the bus
    end else if (pixel_q.size() != 0 && !(pixel_q[0].drain && pending_pieces.size() != 0)
                 && $urandom_range(99) >= gap_pct) begin
      it = pixel_q.pop_front();
      s_tvalid <= 1'b1;
      s_tdata  <= it.value;
      s_tlast  <= it.last;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_px(input logic [31:0] v, input logic last, input logic drain);
    pixel_item_t it;
    it.value = v;
    it.last  = last;
    it.drain = drain;
    pixel_q.push_back(it);
    n_pushed++;
  endtask

  // Every pixel taken and every owed piece delivered, then let the
  // sequencer finish any pixel that caused no piece.
  task automatic wait_idle();
    do @(negedge clk); while (n_taken != n_pushed || pending_pieces.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic set_format(input logic [1:0] f);
    int target;
    wait_idle();
    target = n_cfg + 1;
    cfg_data  <= f;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (n_cfg < target);
    cfg_valid <= 1'b0;
    gen_fmt = f;
  endtask

  // Image made of repeat runs, literal stretches and noise from a tiny
  // alphabet. Bits above the compared width are always random.
  task automatic add_image(input int max_segs, input logic close);
    int          nseg;
    int          len;
    int          kind;
    int          s;
    int          j;
    logic [31:0] keep;
    logic [31:0] base;
    logic [31:0] v;
    keep = width_bits(gen_fmt);
    nseg = $urandom_range(max_segs, 1);
    for (s = 0; s < nseg; s++) begin
      kind = $urandom_range(9);
      len  = $urandom_range(6, 1);
      base = $urandom;
      for (j = 0; j < len; j++) begin
        if (kind < 4) begin
          v = (base & keep) | ($urandom & ~keep);
        end else if (kind < 8) begin
          v = $urandom;
          if (((v ^ gen_prev) & keep) == '0) v ^= 32'h1;
        end else begin
          v = (32'($urandom_range(1)) & keep) | ($urandom & ~keep);
        end
        push_px(v, close && s == nseg - 1 && j == len - 1, 1'b0);
        gen_prev = v;
      end
    end
  endtask

  // An image may stay open at the end of a phase, so the next format write
  // lands mid-image.
  task automatic run_phase(input logic [1:0] f, input int gap, input int stall,
                           input int budget);
    int first;
    set_format(f);
    gap_pct   = gap;
    stall_pct = stall;
    first     = n_pushed;
    add_image(4, 1'b1);
    push_px($urandom, 1'b0, 1'b1);
    while (n_pushed - first < budget) add_image(6, $urandom_range(3) != 0);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int          j;
    logic [31:0] v;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Lone final pixel: one-pixel literal.
    push_px(32'hFFFF_FFFF, 1'b1, 1'b0);
    // Equal run closed by the final pixel.
    repeat (3) push_px(32'h0000_0000, 1'b0, 1'b0);
    push_px(32'h0000_0000, 1'b1, 1'b0);
    // Literal of six, two pieces, extreme patterns.
    push_px(32'h0000_0000, 1'b0, 1'b0);
    push_px(32'hFFFF_FFFF, 1'b0, 1'b0);
    push_px(32'h8000_0000, 1'b0, 1'b0);
    push_px(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_px(32'h5555_5555, 1'b0, 1'b0);
    push_px(32'hAAAA_AAAA, 1'b1, 1'b0);
    // Repeat, literal, repeat of one before the end.
    push_px(32'h0000_0005, 1'b0, 1'b0);
    push_px(32'h0000_0005, 1'b0, 1'b0);
    push_px(32'h0000_0006, 1'b0, 1'b0);
    push_px(32'h0000_0007, 1'b0, 1'b0);
    push_px(32'h0000_0007, 1'b1, 1'b0);

    // 8-bit: upper bits differ but pixels compare equal.
    set_format(FMT_8);
    push_px(32'h1234_56AB, 1'b0, 1'b0);
    push_px(32'hFFFF_FFAB, 1'b0, 1'b0);
    push_px(32'h0000_00AC, 1'b1, 1'b0);

    // Format change mid-image: held pixel keeps its 8-bit value.
    push_px(32'hABCD_1234, 1'b0, 1'b0);
    set_format(FMT_16);
    push_px(32'h9999_0034, 1'b0, 1'b0);
    push_px(32'h5A5A_0034, 1'b0, 1'b0);
    push_px(32'hFFFF_1111, 1'b1, 1'b0);

    // Code 3 behaves as 32-bit.
    set_format(FMT_WIDE);
    push_px(32'hDEAD_BEEF, 1'b0, 1'b0);
    push_px(32'hDEAD_BEEF, 1'b0, 1'b0);
    push_px(32'hDEAD_BEEE, 1'b1, 1'b0);

    // Literal hitting the packet cap: 127 in one packet, then 1.
    gen_prev = '0;
    for (j = 0; j < 128; j++) begin
      v = $urandom;
      if (v == gen_prev) v ^= 32'h1;
      push_px(v, j == 127, 1'b0);
      gen_prev = v;
    end

    run_phase(FMT_8,    0,  0,  12);
    run_phase(FMT_16,   55, 0,  12);
    run_phase(FMT_32,   0,  55, 12);
    run_phase(FMT_WIDE, 36, 36, 12);

    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
